FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the double-ended queue RTL.
// Bodies vanish when SYNTHESIS is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/deq_pkg.sv
// Shared constants, codes and types for the double-ended queue.
// No dependencies; every other RTL file but assert_macros.svh imports this package.
`default_nettype none

package deq_pkg;

	// Storage geometry
	localparam int DEPTH      = 256;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// Transaction field widths
	localparam int KIND_W   = 3;
	localparam int VAL_W    = 32;
	localparam int POS_W    = 8;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;

	// Operation codes carried in the kind field
	typedef enum logic [KIND_W-1:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_READ       = 3'd4
	} op_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;    // input transaction taken this cycle
		logic out_load;  // move stage-1 result into the output register
	} ctrl_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/deq_req_if.sv
// Request channel interface: valid/ready plus the operation payload.
// Depends on deq_pkg.
`default_nettype none

interface deq_req_if;
	import deq_pkg::*;

	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic signed [VAL_W-1:0] value;
	logic [POS_W-1:0]    position;

	modport source (output valid, kind, value, position, input ready);
	modport sink   (input valid, kind, value, position, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/deq_rsp_if.sv
// Response channel interface: valid/ready plus the result payload.
// Depends on deq_pkg.
`default_nettype none

interface deq_rsp_if;
	import deq_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [STATUS_W-1:0]     status;
	logic signed [VAL_W-1:0] read_value;
	logic [COUNT_W-1:0]      count;

	modport source (output valid, status, read_value, count, input ready);
	modport sink   (input valid, status, read_value, count, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/deq_ctrl.sv
// Handshake controller: tracks the stage-1 slot and the output register.
// Depends on deq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module deq_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      deq_pkg::ctrl_cmd_t cmd
);
	import deq_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_BUSY
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_load;
	logic   accept;

	// Stage 1 drains when the output register is free or being emptied
	assign out_load   = (state_q == S_BUSY) && (!out_valid_q || out_ready);
	assign in_ready   = (state_q == S_IDLE) || out_load;
	assign accept     = in_valid && in_ready;
	assign cmd.accept   = accept;
	assign cmd.out_load = out_load;
	assign out_valid  = out_valid_q;

	// State and registered output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= S_BUSY;
			end else if (out_load) begin
				state_q <= S_IDLE;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`ASSERT_NEXT(a_load_sets_valid, clk, arst_n, out_load, out_valid_q)
	`ASSERT_NEXT(a_stall_holds_busy, clk, arst_n, !in_ready, (state_q == S_BUSY) && out_valid_q)
	`ASSERT_IMPLIES(a_idle_ready, clk, arst_n, state_q == S_IDLE, in_ready)

endmodule

`default_nettype wire

FILE: rtl/core/deq_datapath.sv
// Datapath: front pointer, element count, ring store, stage-1 and output registers.
// Depends on deq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module deq_datapath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire deq_pkg::ctrl_cmd_t             cmd,
	input  wire logic [deq_pkg::KIND_W-1:0]     kind,
	input  wire logic signed [deq_pkg::VAL_W-1:0] value,
	input  wire logic [deq_pkg::POS_W-1:0]      position,
	output      logic [deq_pkg::STATUS_W-1:0]   status,
	output      logic signed [deq_pkg::VAL_W-1:0] read_value,
	output      logic [deq_pkg::COUNT_W-1:0]    count
);
	import deq_pkg::*;

	localparam int CMP_W = CNT_W + POS_W;

	// Modular add of two ring indexes, both below DEPTH
	function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
	                                               input logic [ADDR_W-1:0] off);
		logic [ADDR_W:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= (ADDR_W+1)'(DEPTH)) begin
			sum = sum - (ADDR_W+1)'(DEPTH);
		end
		return sum[ADDR_W-1:0];
	endfunction

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];

	logic [ADDR_W-1:0]     front_q;
	logic [CNT_W-1:0]      count_q;

	status_t               status_s1;
	logic                  rd_ok_s1;
	logic [CNT_W-1:0]      count_s1;
	logic [DATA_WIDTH-1:0] rdata_s1;

	status_t               out_status_q;
	logic [DATA_WIDTH-1:0] out_rdata_q;
	logic [CNT_W-1:0]      out_count_q;

	logic                  full;
	logic                  empty;
	logic [ADDR_W-1:0]     back_idx;
	logic [ADDR_W-1:0]     front_dec;
	logic [ADDR_W-1:0]     front_inc;
	logic [ADDR_W-1:0]     rd_idx;
	logic [ADDR_W-1:0]     wr_idx;
	logic                  wr_en;
	logic                  rd_ok;
	status_t               st_nxt;
	logic [ADDR_W-1:0]     front_nxt;
	logic [CNT_W-1:0]      count_nxt;
	logic                  push_ok;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign back_idx  = ring_add(front_q, ADDR_W'(count_q));
	assign front_dec = (front_q == '0) ? ADDR_W'(DEPTH - 1) : front_q - 1'b1;
	assign front_inc = (front_q == ADDR_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;
	assign rd_idx    = ring_add(front_q, ADDR_W'(position));

	// Operation decode and next pointer/count
	always_comb begin
		st_nxt    = ST_OK;
		front_nxt = front_q;
		count_nxt = count_q;
		wr_en     = 1'b0;
		wr_idx    = back_idx;
		rd_ok     = 1'b0;
		case (kind)
			OP_PUSH_BACK: begin
				if (full) begin
					st_nxt = ST_FULL;
				end else begin
					wr_en     = 1'b1;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			OP_PUSH_FRONT: begin
				if (full) begin
					st_nxt = ST_FULL;
				end else begin
					wr_en     = 1'b1;
					wr_idx    = front_dec;
					front_nxt = front_dec;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					st_nxt = ST_EMPTY;
				end else begin
					count_nxt = count_q - CNT_W'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					st_nxt = ST_EMPTY;
				end else begin
					front_nxt = front_inc;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			OP_READ: begin
				if (CMP_W'(position) >= CMP_W'(count_q)) begin
					st_nxt = ST_RANGE;
				end else begin
					rd_ok = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign push_ok = cmd.accept && wr_en;

	// Pointer and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (cmd.accept) begin
			front_q <= front_nxt;
			count_q <= count_nxt;
		end
	end

	// Ring store: a registered read on every transaction, plus one write on a successful push
	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_idx] <= DATA_WIDTH'($unsigned(value));
		end
		if (cmd.accept) begin
			rdata_s1 <= mem_q[rd_idx];
		end
	end

	// Stage-1 result fields
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			status_s1 <= st_nxt;
			rd_ok_s1  <= rd_ok;
			count_s1  <= count_nxt;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= status_s1;
			out_rdata_q  <= rd_ok_s1 ? rdata_s1 : '0;
			out_count_q  <= count_s1;
		end
	end

	assign status     = out_status_q;
	assign read_value = $signed(VAL_W'(out_rdata_q));
	assign count      = COUNT_W'(out_count_q);

	`ASSERT_IMPLIES(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(DEPTH))
	`ASSERT_NEXT(a_push_inc, clk, arst_n, push_ok, count_q == $past(count_q) + CNT_W'(1))
	`ASSERT_NEXT(a_bad_status_zero, clk, arst_n, cmd.out_load && (status_s1 != ST_OK), out_rdata_q == '0)

endmodule

`default_nettype wire

FILE: rtl/core/double_ended_queue_unit.sv
// Bounded double-ended queue on a 256-entry ring store: push/pop at either end and
// indexed read from the front, one result transaction per request transaction. The
// unit takes one request per cycle when results are drained; the accepting edge
// captures the request's result in stage 1 (the registered read port of the ring
// store), and it moves on into the output register, where it is valid, once that
// register is free or being emptied. With the result side stalled, one request
// waits in stage 1 behind the held result, then the request side stalls.
// Depends on deq_pkg, deq_req_if, deq_rsp_if, deq_ctrl and deq_datapath.
`default_nettype none

module double_ended_queue_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	deq_req_if.sink   req,
	deq_rsp_if.source rsp
);
	import deq_pkg::*;

	ctrl_cmd_t cmd;

	// Handshake control
	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	// Queue state and store
	deq_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.kind       (req.kind),
		.value      (req.value),
		.position   (req.position),
		.status     (rsp.status),
		.read_value (rsp.read_value),
		.count      (rsp.count)
	);

endmodule

`default_nettype wire
